// File: hdl/assert_macros.svh
// Assertion macros for the RTL files; cnfs_face_gen includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/cnfs_pkg.sv
package cnfs_pkg;

	localparam int FACE_COUNT = 6;

	typedef logic [2:0] face_t;

	localparam face_t FACE_NEG_Y = 3'd0;
	localparam face_t FACE_POS_X = 3'd1;
	localparam face_t FACE_POS_Y = 3'd2;
	localparam face_t FACE_NEG_X = 3'd3;
	localparam face_t FACE_NEG_Z = 3'd4;
	localparam face_t FACE_POS_Z = 3'd5;
	localparam face_t LAST_FACE  = FACE_POS_Z;

	// matching face of the neighbour, indexed by own face
	localparam face_t PARTNER [FACE_COUNT] = '{
		FACE_POS_Y, FACE_NEG_X, FACE_NEG_Y, FACE_POS_X, FACE_POS_Z, FACE_NEG_Z
	};

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_CELLS_X = 3'd0;
	localparam reg_idx_t REG_CELLS_Y = 3'd1;
	localparam reg_idx_t REG_CELLS_Z = 3'd2;
	localparam reg_idx_t REG_SETS_X  = 3'd3;
	localparam reg_idx_t REG_SETS_Y  = 3'd4;

	typedef struct packed {
		logic [23:0]       local_index;
		logic [11:0]       set_index;
		logic signed [1:0] dir_x_sign;
		logic signed [1:0] dir_y_sign;
		logic signed [1:0] dir_z_sign;
	} item_t;

	typedef struct packed {
		logic [FACE_COUNT-1:0] incoming;
		logic [FACE_COUNT-1:0] crosses;
	} face_flags_t;

endpackage

// File: hdl/cnfs_ifs.sv
interface cnfs_query_if;
	logic              valid;
	logic              ready;
	logic [23:0]       local_index;
	logic [11:0]       set_index;
	logic signed [1:0] dir_x_sign;
	logic signed [1:0] dir_y_sign;
	logic signed [1:0] dir_z_sign;

	modport source(output valid, local_index, set_index, dir_x_sign, dir_y_sign, dir_z_sign,
		input ready);
	modport sink(input valid, local_index, set_index, dir_x_sign, dir_y_sign, dir_z_sign,
		output ready);
endinterface

interface cnfs_face_if;
	logic               valid;
	logic               ready;
	logic [2:0]         face_number;
	logic               is_incoming;
	logic signed [31:0] target_cell;
	logic [2:0]         target_face;
	logic               crosses_set;
	logic               last_face;

	modport source(output valid, face_number, is_incoming, target_cell, target_face,
		crosses_set, last_face, input ready);
	modport sink(input valid, face_number, is_incoming, target_cell, target_face,
		crosses_set, last_face, output ready);
endinterface

// File: hdl/cnfs_div_pipe.sv
module cnfs_div_pipe #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 9,
	parameter int STEP  = 6,
	parameter int PAY_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [PAY_W-1:0] pay,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem,
	output logic [PAY_W-1:0] out_pay
);
	localparam int STAGES = NUM_W / STEP;

	logic [STAGES-1:0] v_s;
	logic [DEN_W-1:0]  rem_s [STAGES];
	logic [NUM_W-1:0]  x_s   [STAGES];
	logic [DEN_W-1:0]  den_s [STAGES];
	logic [PAY_W-1:0]  pay_s [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic             v_in;
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] x_in;
		logic [DEN_W-1:0] den_in;
		logic [PAY_W-1:0] pay_in;
		logic [DEN_W-1:0] rem_nx;
		logic [NUM_W-1:0] x_nx;

		if (g == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = '0;
			assign x_in   = num;
			assign den_in = den;
			assign pay_in = pay;
		end else begin : g_next
			assign v_in   = v_s[g-1];
			assign rem_in = rem_s[g-1];
			assign x_in   = x_s[g-1];
			assign den_in = den_s[g-1];
			assign pay_in = pay_s[g-1];
		end

		// restoring division, STEP quotient bits per stage
		always_comb begin
			logic [DEN_W:0] t;
			logic           qb;
			rem_nx = rem_in;
			x_nx   = x_in;
			for (int s = 0; s < STEP; s++) begin
				t = {rem_nx, x_nx[NUM_W-1]};
				if (t >= {1'b0, den_in}) begin
					t  = t - {1'b0, den_in};
					qb = 1'b1;
				end else begin
					qb = 1'b0;
				end
				rem_nx = t[DEN_W-1:0];
				x_nx   = {x_nx[NUM_W-2:0], qb};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				x_s[g]   <= x_nx;
				den_s[g] <= den_in;
				pay_s[g] <= pay_in;
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign quo       = x_s[STAGES-1];
	assign rem       = rem_s[STAGES-1];
	assign out_pay   = pay_s[STAGES-1];

endmodule

// File: hdl/cnfs_face_gen.sv
`include "assert_macros.svh"

module cnfs_face_gen #(
	parameter int ID_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	input  logic [ID_WIDTH-1:0]   tcell [cnfs_pkg::FACE_COUNT],
	input  cnfs_pkg::face_t       tface [cnfs_pkg::FACE_COUNT],
	input  cnfs_pkg::face_flags_t flags,
	output logic                  can_load,
	cnfs_face_if.source           faces
);
	import cnfs_pkg::*;

	logic                full_q;
	face_t               cnt_q;
	logic [ID_WIDTH-1:0] tcell_q [FACE_COUNT];
	face_t               tface_q [FACE_COUNT];
	face_flags_t         flags_q;
	logic                finishing;
	logic                load;
	logic [ID_WIDTH+31:0] cell_ext;

	assign finishing = full_q && faces.ready && (cnt_q == LAST_FACE);
	assign can_load  = !full_q || finishing;
	assign load      = can_load && load_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			cnt_q  <= FACE_NEG_Y;
		end else begin
			if (load) begin
				full_q <= 1'b1;
				cnt_q  <= FACE_NEG_Y;
			end else if (finishing) begin
				full_q <= 1'b0;
				cnt_q  <= FACE_NEG_Y;
			end else if (full_q && faces.ready) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tcell_q <= tcell;
			tface_q <= tface;
			flags_q <= flags;
		end
	end

	// keep the low 32 bits, zero above a narrow id
	assign cell_ext = {32'b0, tcell_q[cnt_q]};

	assign faces.valid       = full_q;
	assign faces.face_number = cnt_q;
	assign faces.is_incoming = flags_q.incoming[cnt_q];
	assign faces.target_cell = cell_ext[31:0];
	assign faces.target_face = tface_q[cnt_q];
	assign faces.crosses_set = flags_q.crosses[cnt_q];
	assign faces.last_face   = (cnt_q == LAST_FACE);

	`ASSERT_NEXT(a_face_advance, clk, arst_n, full_q && faces.ready && cnt_q != LAST_FACE && !load, full_q && cnt_q == $past(cnt_q) + 3'd1)
	`ASSERT_IMPLIES(a_load_free, clk, arst_n, load, !full_q || finishing)
	`ASSERT_IMPLIES(a_cnt_range, clk, arst_n, full_q, cnt_q <= LAST_FACE)

endmodule

// File: hdl/cell_neighbor_face_sweep.sv
// Channel   Dir  Handshake       Payload
// query     in   valid / ready   local_index, set_index, dir_x/y/z_sign
// faces     out  valid / ready   face_number, is_incoming, target_cell, target_face,
//                                crosses_set, last_face
// config    in   APB, pready=1   five registers at byte addresses 0, 4, 8, 12, 16
//
// An item emits six face transactions, one per cycle while faces is ready; a new item enters
// the single face output register only as the last face of the current one is accepted. A
// query passes two 4-stage divider pipelines and stages s1 to s4 to reach that register.
// Reset clears valid bits, the face counter and sets every configuration register to one.
// A stall on faces holds the whole pipeline; nothing is dropped or repeated.
module cell_neighbor_face_sweep #(
	parameter int ID_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	cnfs_query_if.sink  query,
	cnfs_face_if.source faces,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cnfs_pkg::*;

	typedef struct packed {
		item_t       item;
		logic [8:0]  i;
		logic [17:0] plane;
	} div2_pay_t;

	// configuration registers
	logic [8:0] cx_q, cy_q, cz_q;
	logic [6:0] sx_q, sy_q;
	logic [8:0] cx_eff, cy_eff, cz_eff;
	reg_idx_t   widx;

	assign pready = 1'b1;
	assign widx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= 9'd1;
			cy_q <= 9'd1;
			cz_q <= 9'd1;
			sx_q <= 7'd1;
			sy_q <= 7'd1;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				REG_CELLS_X: cx_q <= pwdata[8:0];
				REG_CELLS_Y: cy_q <= pwdata[8:0];
				REG_CELLS_Z: cz_q <= pwdata[8:0];
				REG_SETS_X:  sx_q <= pwdata[6:0];
				REG_SETS_Y:  sy_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_CELLS_X: prdata = {23'b0, cx_q};
			REG_CELLS_Y: prdata = {23'b0, cy_q};
			REG_CELLS_Z: prdata = {23'b0, cz_q};
			REG_SETS_X:  prdata = {25'b0, sx_q};
			REG_SETS_Y:  prdata = {25'b0, sy_q};
			default:     prdata = '0;
		endcase
	end

	// a zero cell count acts as one
	assign cx_eff = (cx_q == 9'd0) ? 9'd1 : cx_q;
	assign cy_eff = (cy_q == 9'd0) ? 9'd1 : cy_q;
	assign cz_eff = (cz_q == 9'd0) ? 9'd1 : cz_q;

	logic  adv;
	item_t query_item;

	assign query.ready = adv;
	assign query_item  = '{local_index: query.local_index, set_index: query.set_index,
		dir_x_sign: query.dir_x_sign, dir_y_sign: query.dir_y_sign,
		dir_z_sign: query.dir_z_sign};

	// local / cx gives i and the plane-row quotient
	logic        d1_valid;
	logic [23:0] d1_quo;
	logic [8:0]  d1_rem;
	item_t       d1_pay;

	cnfs_div_pipe #(.NUM_W(24), .DEN_W(9), .STEP(6), .PAY_W($bits(item_t))) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(query.valid),
		.num(query.local_index), .den(cx_eff), .pay(query_item),
		.out_valid(d1_valid), .quo(d1_quo), .rem(d1_rem), .out_pay(d1_pay)
	);

	logic        v_s1;
	logic [23:0] q1_s1;
	div2_pay_t   p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q1_s1         <= d1_quo;
			p_s1.item     <= d1_pay;
			p_s1.i        <= d1_rem;
			p_s1.plane    <= 18'(cx_eff) * 18'(cy_eff);
		end
	end

	// quotient / cy gives k and j
	logic        d2_valid;
	logic [23:0] d2_quo;
	logic [8:0]  d2_rem;
	div2_pay_t   d2_pay;

	cnfs_div_pipe #(.NUM_W(24), .DEN_W(9), .STEP(6), .PAY_W($bits(div2_pay_t))) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.num(q1_s1), .den(cy_eff), .pay(p_s1),
		.out_valid(d2_valid), .quo(d2_quo), .rem(d2_rem), .out_pay(d2_pay)
	);

	logic        v_s2, v_s3, v_s4;
	item_t       item_s2;
	logic [17:0] plane_s2, plane_s3, plane_s4;
	logic [26:0] per_s2, per_s3, per_s4;
	logic [17:0] jcx_s2, jcx_s3, jcx_s4;
	logic [41:0] kp_s2, kp_s3, kp_s4;
	face_flags_t flags_s2, flags_s3, flags_s4;
	logic [ID_WIDTH-1:0] own_s3, own_s4;
	logic [33:0] row_s3, row_s4;
	logic [40:0] slab_s4;

	logic d2_pos_x, d2_neg_x, d2_pos_y, d2_neg_y, d2_pos_z, d2_neg_z;
	assign d2_pos_x = (d2_pay.item.dir_x_sign == 2'sd1);
	assign d2_neg_x = d2_pay.item.dir_x_sign[1];
	assign d2_pos_y = (d2_pay.item.dir_y_sign == 2'sd1);
	assign d2_neg_y = d2_pay.item.dir_y_sign[1];
	assign d2_pos_z = (d2_pay.item.dir_z_sign == 2'sd1);
	assign d2_neg_z = d2_pay.item.dir_z_sign[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= d2_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2  <= d2_pay.item;
			plane_s2 <= d2_pay.plane;
			per_s2   <= 27'(d2_pay.plane) * 27'(cz_eff);
			jcx_s2   <= 18'(d2_rem) * 18'(cx_eff);
			kp_s2    <= 42'(d2_quo) * 42'(d2_pay.plane);
			// the low mark wins on a single-cell axis
			flags_s2.crosses[FACE_NEG_Y] <= (d2_rem == 9'd0);
			flags_s2.crosses[FACE_POS_X] <= (d2_pay.i != 9'd0) && (d2_pay.i == cx_eff - 9'd1);
			flags_s2.crosses[FACE_POS_Y] <= (d2_rem != 9'd0) && (d2_rem == cy_eff - 9'd1);
			flags_s2.crosses[FACE_NEG_X] <= (d2_pay.i == 9'd0);
			flags_s2.crosses[FACE_NEG_Z] <= (d2_quo == 24'd0);
			flags_s2.crosses[FACE_POS_Z] <= (d2_quo != 24'd0) &&
				(d2_quo == 24'(cz_eff - 9'd1));
			flags_s2.incoming[FACE_NEG_Y] <= d2_pos_y;
			flags_s2.incoming[FACE_POS_X] <= d2_neg_x;
			flags_s2.incoming[FACE_POS_Y] <= d2_neg_y;
			flags_s2.incoming[FACE_NEG_X] <= d2_pos_x;
			flags_s2.incoming[FACE_NEG_Z] <= d2_pos_z;
			flags_s2.incoming[FACE_POS_Z] <= d2_neg_z;

			plane_s3 <= plane_s2;
			per_s3   <= per_s2;
			jcx_s3   <= jcx_s2;
			kp_s3    <= kp_s2;
			flags_s3 <= flags_s2;
			own_s3   <= ID_WIDTH'(39'(item_s2.set_index) * 39'(per_s2)) +
				ID_WIDTH'(item_s2.local_index);
			row_s3   <= 34'(per_s2) * 34'(sx_q);

			plane_s4 <= plane_s3;
			per_s4   <= per_s3;
			jcx_s4   <= jcx_s3;
			kp_s4    <= kp_s3;
			flags_s4 <= flags_s3;
			own_s4   <= own_s3;
			row_s4   <= row_s3;
			slab_s4  <= 41'(row_s3) * 41'(sy_q);
		end
	end

	// neighbour ids, wrapping at ID_WIDTH bits
	logic [ID_WIDTH-1:0] plane_id, per_id, row_id, slab_id, jcx_id, kp_id, cx_id, one_id;
	logic [ID_WIDTH-1:0] nid   [FACE_COUNT];
	logic [ID_WIDTH-1:0] tcell [FACE_COUNT];
	face_t               tface [FACE_COUNT];

	assign plane_id = ID_WIDTH'(plane_s4);
	assign per_id   = ID_WIDTH'(per_s4);
	assign row_id   = ID_WIDTH'(row_s4);
	assign slab_id  = ID_WIDTH'(slab_s4);
	assign jcx_id   = ID_WIDTH'(jcx_s4);
	assign kp_id    = ID_WIDTH'(kp_s4);
	assign cx_id    = ID_WIDTH'(cx_eff);
	assign one_id   = ID_WIDTH'(1);

	always_comb begin
		nid[FACE_NEG_Y] = flags_s4.crosses[FACE_NEG_Y] ?
			own_s4 - row_id + (plane_id - cx_id - jcx_id) : own_s4 - cx_id;
		nid[FACE_POS_X] = flags_s4.crosses[FACE_POS_X] ?
			own_s4 + per_id - (cx_id - one_id) : own_s4 + one_id;
		nid[FACE_POS_Y] = flags_s4.crosses[FACE_POS_Y] ?
			own_s4 + row_id - jcx_id : own_s4 + cx_id;
		nid[FACE_NEG_X] = flags_s4.crosses[FACE_NEG_X] ?
			own_s4 - per_id + (cx_id - one_id) : own_s4 - one_id;
		nid[FACE_NEG_Z] = flags_s4.crosses[FACE_NEG_Z] ?
			own_s4 - slab_id + (per_id - kp_id) : own_s4 - plane_id;
		nid[FACE_POS_Z] = flags_s4.crosses[FACE_POS_Z] ?
			own_s4 + slab_id - kp_id : own_s4 + plane_id;
		// outgoing across sets: point back at own cell and face
		for (int f = 0; f < FACE_COUNT; f++) begin
			if (!flags_s4.incoming[f] && flags_s4.crosses[f]) begin
				tcell[f] = own_s4;
				tface[f] = face_t'(f);
			end else begin
				tcell[f] = nid[f];
				tface[f] = PARTNER[f];
			end
		end
	end

	cnfs_face_gen #(.ID_WIDTH(ID_WIDTH)) u_face_gen (
		.clk(clk), .arst_n(arst_n), .load_valid(v_s4),
		.tcell(tcell), .tface(tface), .flags(flags_s4),
		.can_load(adv), .faces(faces)
	);

endmodule
